FILE: design/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg
// Types, codes and default sizes for the timer deadline scheduler.
// ----------------------------------------------------------------------------
package tds_pkg;

   localparam int NUM_TIMERS_DEF   = 16;
   localparam int TIME_BITS_DEF    = 32;

   localparam int OP_W     = 3;
   localparam int ID_W     = 4;
   localparam int DELAY_W  = 16;
   localparam int PERIOD_W = 16;
   localparam int WAIT_W   = 16;
   localparam int KIND_W   = 2;
   localparam int REQ_DW   = 24;
   localparam int RSP_DW   = 24;

   localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = 16'd4;

   localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_W-1:0] OP_ONESHOT  = 3'd1;
   localparam logic [OP_W-1:0] OP_PERIODIC = 3'd2;
   localparam logic [OP_W-1:0] OP_CANCEL   = 3'd3;
   localparam logic [OP_W-1:0] OP_IMMED    = 3'd4;

   localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ACK,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage

FILE: design/timer_deadline_scheduler_top.sv
// ----------------------------------------------------------------------------
// timer_deadline_scheduler_top
// Table of timer slots fired in deadline order on each tick.
//
// req_ carries one command word: tick, arm one-shot, arm periodic, cancel or
// arm immediate. csr_ writes the minimum period. rsp_ returns result words:
// one acknowledge per arm or cancel; per tick one word per fired timer in
// deadline order, lowest slot first on ties, then a summary word with tlast.
// Slot deadlines and periods live in a single-port-read memory; a tick runs
// repeated scans over it, each making one read a cycle through two
// pipeline stages, then a drain step and a decision step. A tick needs
// 1 + fired + dropped scans.
// One command is in work at a time; req_tready is high when idle.
// A stalled rsp_ holds its word and the scan waits at the decision step.
// Reset clears time, held wait and all slot flags; slot memory needs no
// clearing, so the block takes commands in the first cycle after reset.
// ----------------------------------------------------------------------------
module timer_deadline_scheduler_top
   import tds_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // req_tdata: timer_id[3:0], delay[19:4], zero pad
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,
   // req_tuser: operation
   input  logic [OP_W-1:0]   req_tuser,
   // rsp_tdata: fired_id[3:0], any_pending[4], next_wait[20:5], zero pad
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,
   // rsp_tuser: kind
   output logic [KIND_W-1:0] rsp_tuser,
   output logic              rsp_tlast,
   input  logic              csr_tvalid,
   output logic              csr_tready,
   input  logic [PERIOD_W-1:0] csr_tdata
);

   localparam int IDX_W    = $clog2(NUM_TIMERS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int ID_CMP_W = (IDX_W + 1 > ID_W) ? IDX_W + 1 : ID_W;
   localparam int ENTRY_W  = TIME_BITS + PERIOD_W;
   localparam int WIDE_W   = TIME_BITS + WAIT_W;
   localparam logic [TIME_BITS-1:0] TIME_SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_TIMERS);

   state_type state_ff, state_in;

   logic [PERIOD_W-1:0]   min_period_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic [WAIT_W-1:0]     held_ff;
   logic [NUM_TIMERS-1:0] pending_ff, periodic_ff, cancelled_ff, uncanc_ff, fired_ff;

   logic [OP_W-1:0]       op_ff;
   logic [ID_W-1:0]       id_ff;
   logic [DELAY_W-1:0]    delay_ff;

   logic [ENTRY_W-1:0]    slot_mem [NUM_TIMERS];
   logic [ENTRY_W-1:0]    rd_q;

   logic [CNT_W-1:0]      cnt_ff;
   logic                  rd_valid_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  diff_valid_ff;
   logic [IDX_W-1:0]      diff_idx_ff;
   logic [TIME_BITS-1:0]  diff_ff, diff_dl_ff;
   logic [PERIOD_W-1:0]   diff_per_ff;

   logic                  best_found_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [TIME_BITS-1:0]  best_key_ff, best_dl_ff;
   logic [PERIOD_W-1:0]   best_per_ff;
   logic                  wany_ff;
   logic [WAIT_W-1:0]     best_w_ff;

   logic                  rsp_valid_ff, rsp_pend_ff, rsp_last_ff;
   logic [KIND_W-1:0]     rsp_kind_ff;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [WAIT_W-1:0]     rsp_wait_ff;

   logic                  out_free, scan_issue, scan_done;
   logic                  id_in_range;
   logic [IDX_W-1:0]      aidx;
   logic [PERIOD_W-1:0]   lo_period, clamp_period;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [ENTRY_W-1:0]    mem_wdata;
   logic                  arm_en, arm_per, arm_unc, cancel_en, drop_en, fire_mark;
   logic                  tick_start, scan_start, held_load;
   logic                  out_load, out_pend, out_last;
   logic [KIND_W-1:0]     out_kind;
   logic [ID_W-1:0]       out_id;
   logic [WAIT_W-1:0]     out_wait;

   logic                  st_due, st_pend, st_cand;
   logic [TIME_BITS-1:0]  st_key;
   logic [WIDE_W-1:0]     st_diff_x;
   logic [WAIT_W-1:0]     st_w;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign scan_issue   = (state_ff == ST_SCAN) && (cnt_ff < CNT_END);
   assign scan_done    = (state_ff == ST_SCAN) && (cnt_ff == CNT_END)
                         && !rd_valid_ff && !diff_valid_ff;
   assign id_in_range  = ID_CMP_W'(id_ff) < ID_CMP_W'(NUM_TIMERS);
   assign aidx         = IDX_W'(id_ff);
   assign lo_period    = (min_period_ff == '0) ? PERIOD_W'(1) : min_period_ff;
   assign clamp_period = (delay_ff < lo_period) ? lo_period : delay_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DW-ID_W-1-WAIT_W){1'b0}}, rsp_wait_ff, rsp_pend_ff, rsp_id_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC:   state_in = (op_ff == OP_TICK) ? ST_SCAN : ST_ACK;
         ST_ACK:    if (out_free) state_in = ST_IDLE;
         ST_SCAN:   if (scan_done) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (best_found_ff) begin
               if (cancelled_ff[best_idx_ff] || out_free) state_in = ST_SCAN;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = aidx;
      mem_wdata  = '0;
      arm_en     = 1'b0;
      arm_per    = 1'b0;
      arm_unc    = 1'b0;
      cancel_en  = 1'b0;
      drop_en    = 1'b0;
      fire_mark  = 1'b0;
      tick_start = 1'b0;
      scan_start = 1'b0;
      held_load  = 1'b0;
      out_load   = 1'b0;
      out_kind   = KIND_ACK;
      out_id     = id_ff;
      out_pend   = |pending_ff;
      out_wait   = held_ff;
      out_last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: ;
         ST_EXEC: begin
            unique case (op_ff)
               OP_TICK: begin
                  tick_start = 1'b1;
                  scan_start = 1'b1;
               end
               OP_ONESHOT: begin
                  mem_we    = id_in_range;
                  arm_en    = id_in_range;
                  mem_wdata = {now_ff + TIME_BITS'(delay_ff), {PERIOD_W{1'b0}}};
               end
               OP_PERIODIC: begin
                  mem_we    = id_in_range;
                  arm_en    = id_in_range;
                  arm_per   = 1'b1;
                  mem_wdata = {now_ff + TIME_BITS'(clamp_period), clamp_period};
               end
               OP_CANCEL: begin
                  cancel_en = id_in_range && pending_ff[aidx] && !uncanc_ff[aidx];
               end
               OP_IMMED: begin
                  mem_we    = id_in_range;
                  arm_en    = id_in_range;
                  arm_unc   = 1'b1;
                  mem_wdata = {now_ff, {PERIOD_W{1'b0}}};
               end
               default: ;
            endcase
         end
         ST_ACK: out_load = out_free;
         ST_SCAN: ;
         ST_DECIDE: begin
            if (best_found_ff) begin
               if (cancelled_ff[best_idx_ff]) begin
                  drop_en    = 1'b1;
                  scan_start = 1'b1;
               end else if (out_free) begin
                  out_load   = 1'b1;
                  out_kind   = KIND_FIRED;
                  out_id     = ID_W'(best_idx_ff);
                  out_pend   = 1'b0;
                  out_wait   = '0;
                  out_last   = 1'b0;
                  scan_start = 1'b1;
                  if (periodic_ff[best_idx_ff]) begin
                     mem_we    = 1'b1;
                     mem_waddr = best_idx_ff;
                     mem_wdata = {best_dl_ff + TIME_BITS'(best_per_ff), best_per_ff};
                     fire_mark = 1'b1;
                  end else begin
                     drop_en = 1'b1;
                  end
               end
            end else begin
               out_load  = out_free;
               held_load = out_free && wany_ff;
               out_kind  = KIND_SUMMARY;
               out_id    = '0;
               out_pend  = wany_ff;
               out_wait  = wany_ff ? best_w_ff : held_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
      if (scan_issue) rd_q <= slot_mem[cnt_ff[IDX_W-1:0]];
   end

   // scan stage: candidate and wait
   always_comb begin
      st_due    = (diff_ff == '0) || diff_ff[TIME_BITS-1];
      st_pend   = pending_ff[diff_idx_ff];
      st_cand   = st_pend && !fired_ff[diff_idx_ff] && st_due;
      st_key    = diff_ff ^ TIME_SIGN;
      st_diff_x = WIDE_W'(diff_ff);
      if (st_due)
         st_w = '0;
      else if (|st_diff_x[WIDE_W-1:WAIT_W])
         st_w = '1;
      else
         st_w = st_diff_x[WAIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_period_ff <= MIN_PERIOD_RESET;
         now_ff        <= '0;
         held_ff       <= '0;
         pending_ff    <= '0;
         periodic_ff   <= '0;
         cancelled_ff  <= '0;
         uncanc_ff     <= '0;
         fired_ff      <= '0;
         cnt_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         diff_valid_ff <= 1'b0;
         best_found_ff <= 1'b0;
         wany_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_tvalid) min_period_ff <= csr_tdata;
         if (tick_start) now_ff <= now_ff + TIME_BITS'(1);
         if (held_load) held_ff <= best_w_ff;

         if (arm_en) begin
            pending_ff[aidx]   <= 1'b1;
            periodic_ff[aidx]  <= arm_per;
            cancelled_ff[aidx] <= 1'b0;
            uncanc_ff[aidx]    <= arm_unc;
         end
         if (cancel_en) cancelled_ff[aidx] <= 1'b1;
         if (drop_en) pending_ff[best_idx_ff] <= 1'b0;
         if (tick_start) fired_ff <= '0;
         if (fire_mark) fired_ff[best_idx_ff] <= 1'b1;

         rd_valid_ff   <= scan_issue;
         diff_valid_ff <= rd_valid_ff;
         if (scan_start) begin
            cnt_ff        <= '0;
            best_found_ff <= 1'b0;
            wany_ff       <= 1'b0;
         end else begin
            if (scan_issue) cnt_ff <= cnt_ff + CNT_W'(1);
            if (diff_valid_ff && st_cand &&
                (!best_found_ff || st_key < best_key_ff)) begin
               best_found_ff <= 1'b1;
            end
            if (diff_valid_ff && st_pend) begin
               wany_ff <= 1'b1;
            end
         end

         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser;
         id_ff    <= req_tdata[ID_W-1:0];
         delay_ff <= req_tdata[ID_W+DELAY_W-1:ID_W];
      end
      rd_idx_ff   <= cnt_ff[IDX_W-1:0];
      diff_idx_ff <= rd_idx_ff;
      diff_ff     <= rd_q[ENTRY_W-1:PERIOD_W] - now_ff;
      diff_dl_ff  <= rd_q[ENTRY_W-1:PERIOD_W];
      diff_per_ff <= rd_q[PERIOD_W-1:0];
      if (diff_valid_ff && st_cand && (!best_found_ff || st_key < best_key_ff)) begin
         best_idx_ff <= diff_idx_ff;
         best_key_ff <= st_key;
         best_dl_ff  <= diff_dl_ff;
         best_per_ff <= diff_per_ff;
      end
      if (diff_valid_ff && st_pend && (!wany_ff || st_w < best_w_ff)) best_w_ff <= st_w;
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_id_ff   <= out_id;
         rsp_pend_ff <= out_pend;
         rsp_wait_ff <= out_wait;
         rsp_last_ff <= out_last;
      end
   end

   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_FIRED) |-> !rsp_last_ff)
      else $error("fired word carries tlast");

   a_fire_live_slot: assert property (@(posedge clock) disable iff (reset)
      out_load && (out_kind == KIND_FIRED) |->
         best_found_ff && pending_ff[best_idx_ff] && !cancelled_ff[best_idx_ff])
      else $error("fired slot not live");

   a_fired_pending: assert property (@(posedge clock) disable iff (reset)
      (fired_ff & ~pending_ff) == '0)
      else $error("fired mark on idle slot");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff || diff_valid_ff) |-> (state_ff == ST_SCAN))
      else $error("scan pipeline busy outside scan");

endmodule

FILE: dv/timer_deadline_scheduler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_deadline_scheduler_top_tb
// Self-checking bench for the timer deadline scheduler. A behavioural copy of
// the slot table predicts every fired, summary and acknowledge word for each
// accepted command. Result words are checked in order against that forecast.
// Directed cases cover ties, cancels, re-arms and the period clamp. A long
// receiver hold-off fills the block. Random traffic then runs under several
// sender and receiver idling mixes and minimum period settings.
// ----------------------------------------------------------------------------
module timer_deadline_scheduler_top_tb;
   import tds_pkg::*;

   localparam int N_SLOTS          = NUM_TIMERS_DEF;
   localparam int T_BITS           = TIME_BITS_DEF;
   localparam int RESET_CYCLES     = 5;
   localparam int SETTLE_CYCLES    = 8;
   localparam int END_CYCLES       = 40;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int MAX_REPORTS      = 60;
   localparam int ITEMS_PER_PHASE  = 50;

   localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;
   localparam logic [T_BITS-1:0] T_SIGN = {1'b1, {(T_BITS-1){1'b0}}};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   slot;
      logic              pending;
      logic [WAIT_W-1:0] wait_ticks;
      logic              is_last;
   } rsp_word_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata  = '0;
   logic [OP_W-1:0]     req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic [KIND_W-1:0]   rsp_tuser;
   logic                rsp_tlast;
   logic                csr_tvalid = 1'b0;
   logic                csr_tready;
   logic [PERIOD_W-1:0] csr_tdata  = '0;

   // timer table as the block should hold it
   logic [T_BITS-1:0]   tm_now;
   logic [T_BITS-1:0]   tm_deadline [N_SLOTS];
   logic [PERIOD_W-1:0] tm_period   [N_SLOTS];
   logic [N_SLOTS-1:0]  tm_pending;
   logic [N_SLOTS-1:0]  tm_periodic;
   logic [N_SLOTS-1:0]  tm_cancelled;
   logic [N_SLOTS-1:0]  tm_locked;
   logic [WAIT_W-1:0]   tm_held_wait;
   logic [PERIOD_W-1:0] tm_min_period;

   rsp_word_type expected_rsp_q[$];

   int errors          = 0;
   int cycle_count     = 0;
   int idle_pct        = 0;
   int stall_pct       = 0;
   int rsp_hold_cycles = 0;

   timer_deadline_scheduler_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, expected_rsp_q.size());
         $display("timer_deadline_scheduler_top_tb failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready      <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[3:0], rsp_tdata[4], rsp_tdata[20:5], rsp_tlast};
         if (expected_rsp_q.size() == 0) begin
            errors++;
            if (errors < MAX_REPORTS)
               $display("%0t: unexpected word, expected none, actual kind %0d slot %0d",
                        $time, got.kind, got.slot);
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot ||
                got.pending !== want.pending || got.wait_ticks !== want.wait_ticks ||
                got.is_last !== want.is_last) begin
               errors++;
               if (errors < MAX_REPORTS)
                  $display("%0t: expected %0d %0d %0d %0d %0d, actual %0d %0d %0d %0d %0d",
                           $time, want.kind, want.slot, want.pending, want.wait_ticks,
                           want.is_last, got.kind, got.slot, got.pending, got.wait_ticks,
                           got.is_last);
            end
         end
      end
   end

   function automatic logic slot_due(input logic [T_BITS-1:0] diff);
      return (diff == '0) || diff[T_BITS-1];
   endfunction

   task automatic clear_table();
      tm_now        = '0;
      tm_held_wait  = '0;
      tm_min_period = MIN_PERIOD_RESET;
      tm_pending    = '0;
      tm_periodic   = '0;
      tm_cancelled  = '0;
      tm_locked     = '0;
      for (int s = 0; s < N_SLOTS; s++) begin
         tm_deadline[s] = '0;
         tm_period[s]   = '0;
      end
   endtask

   task automatic arm_slot(input int s, input logic [T_BITS-1:0] deadline,
                           input logic [PERIOD_W-1:0] period, input logic periodic,
                           input logic locked);
      tm_deadline[s]  = deadline;
      tm_period[s]    = period;
      tm_pending[s]   = 1'b1;
      tm_periodic[s]  = periodic;
      tm_cancelled[s] = 1'b0;
      tm_locked[s]    = locked;
   endtask

   task automatic predict_tick();
      logic [N_SLOTS-1:0]  fired_now;
      logic                found;
      logic                any;
      int                  pick;
      logic [T_BITS-1:0]   diff;
      logic [T_BITS-1:0]   key;
      logic [T_BITS-1:0]   pkey;
      logic [WAIT_W-1:0]   w;
      logic [WAIT_W-1:0]   best;
      fired_now = '0;
      tm_now    = tm_now + T_BITS'(1);
      found     = 1'b1;
      while (found) begin
         found = 1'b0;
         pick  = 0;
         pkey  = '0;
         for (int s = 0; s < N_SLOTS; s++) begin
            diff = tm_deadline[s] - tm_now;
            key  = diff ^ T_SIGN;
            if (tm_pending[s] && !fired_now[s] && slot_due(diff) && (!found || key < pkey)) begin
               found = 1'b1;
               pick  = s;
               pkey  = key;
            end
         end
         if (found) begin
            if (tm_cancelled[pick]) begin
               tm_pending[pick] = 1'b0;
            end else begin
               expected_rsp_q.push_back('{KIND_FIRED, pick[ID_W-1:0], 1'b0, '0, 1'b0});
               if (tm_periodic[pick]) begin
                  tm_deadline[pick] = tm_deadline[pick] + T_BITS'(tm_period[pick]);
                  fired_now[pick]   = 1'b1;
               end else begin
                  tm_pending[pick] = 1'b0;
               end
            end
         end
      end
      any  = 1'b0;
      best = '0;
      for (int s = 0; s < N_SLOTS; s++) begin
         if (tm_pending[s]) begin
            diff = tm_deadline[s] - tm_now;
            if (slot_due(diff))
               w = '0;
            else if (diff > T_BITS'(16'hFFFF))
               w = '1;
            else
               w = diff[WAIT_W-1:0];
            if (!any || w < best)
               best = w;
            any = 1'b1;
         end
      end
      if (any)
         tm_held_wait = best;
      expected_rsp_q.push_back('{KIND_SUMMARY, '0, any, tm_held_wait, 1'b1});
   endtask

   task automatic predict_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                  input logic [DELAY_W-1:0] delay);
      logic [PERIOD_W-1:0] floor_p;
      logic [PERIOD_W-1:0] p;
      if (op == OP_TICK) begin
         predict_tick();
      end else begin
         case (op)
            OP_ONESHOT: begin
               arm_slot(int'(id), tm_now + T_BITS'(delay), '0, 1'b0, 1'b0);
            end
            OP_PERIODIC: begin
               floor_p = (tm_min_period == '0) ? PERIOD_W'(1) : tm_min_period;
               p       = (delay < floor_p) ? floor_p : delay;
               arm_slot(int'(id), tm_now + T_BITS'(p), p, 1'b1, 1'b0);
            end
            OP_CANCEL: begin
               if (tm_pending[id] && !tm_locked[id])
                  tm_cancelled[id] = 1'b1;
            end
            OP_IMMED: begin
               arm_slot(int'(id), tm_now, '0, 1'b0, 1'b1);
            end
            default: ;
         endcase
         expected_rsp_q.push_back('{KIND_ACK, id, |tm_pending, tm_held_wait, 1'b1});
      end
   endtask

   task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [DELAY_W-1:0] delay);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DW-ID_W-DELAY_W){1'b0}}, delay, id};
      do @(posedge clock); while (!req_tready);
      predict_command(op, id, delay);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_min_period(input logic [PERIOD_W-1:0] value);
      wait_idle();
      csr_tvalid <= 1'b1;
      csr_tdata  <= value;
      do @(posedge clock); while (!csr_tready);
      tm_min_period = value;
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_word(OP_TICK, ID_W'($urandom_range(15)),
                           DELAY_W'($urandom_range(16'hFFFF)));
   endtask

   task automatic test_directed_ops();
      send_word(OP_TICK, 4'd0, 16'd0);
      send_word(OP_ONESHOT, 4'd0, 16'd0);
      send_word(OP_IMMED, 4'd15, 16'hFFFF);
      send_word(OP_CANCEL, 4'd15, 16'd0);
      send_word(OP_CANCEL, 4'd9, 16'd0);
      send_word(OP_ONESHOT, 4'd3, 16'd2);
      send_word(OP_CANCEL, 4'd3, 16'd0);
      send_word(OP_ONESHOT, 4'd4, 16'd1);
      send_word(OP_CANCEL, 4'd4, 16'd0);
      send_word(OP_ONESHOT, 4'd4, 16'd1);
      send_word(OP_PERIODIC, 4'd5, 16'd1);
      send_word(OP_ONESHOT, 4'd7, 16'hFFFF);
      send_word(OP_ONESHOT, 4'd7, 16'd3);
      send_word(OP_PERIODIC, 4'd10, 16'd0);
      for (int op = int'(OP_RSVD_FIRST); op <= int'(OP_RSVD_LAST); op++)
         send_word(op[OP_W-1:0], 4'(op + 8), 16'hA5A5);
      send_ticks(5);
      send_word(OP_CANCEL, 4'd5, 16'd0);
      send_ticks(5);
   endtask

   task automatic test_min_period();
      write_min_period(16'd0);
      send_word(OP_PERIODIC, 4'd6, 16'd0);
      send_ticks(3);
      write_min_period(16'hFFFF);
      send_word(OP_PERIODIC, 4'd6, 16'd1);
      send_ticks(2);
      write_min_period(16'd1);
      send_word(OP_PERIODIC, 4'd8, 16'd0);
      send_word(OP_PERIODIC, 4'd11, 16'd2);
      send_ticks(3);
      send_word(OP_CANCEL, 4'd8, 16'd0);
      send_word(OP_ONESHOT, 4'd6, 16'd0);
      send_word(OP_ONESHOT, 4'd11, 16'd0);
      send_ticks(2);
      write_min_period(MIN_PERIOD_RESET);
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      @(posedge clock);
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      @(negedge clock);
      send_word(OP_IMMED, 4'd1, 16'd0);
      send_word(OP_IMMED, 4'd2, 16'd0);
      send_word(OP_ONESHOT, 4'd3, 16'd0);
      send_word(OP_PERIODIC, 4'd12, 16'd0);
      send_ticks(4);
      wait_idle();
   endtask

   task automatic send_random_word();
      int                  r;
      logic [OP_W-1:0]     op;
      logic [DELAY_W-1:0]  delay;
      r     = int'($urandom_range(99));
      delay = ($urandom_range(4) == 0) ? DELAY_W'($urandom_range(16'hFFFF))
                                       : DELAY_W'($urandom_range(12));
      if (r < 40)
         op = OP_TICK;
      else if (r < 62)
         op = OP_ONESHOT;
      else if (r < 73)
         op = OP_PERIODIC;
      else if (r < 86)
         op = OP_CANCEL;
      else if (r < 95)
         op = OP_IMMED;
      else
         op = OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
      send_word(op, ID_W'($urandom_range(15)), delay);
   endtask

   task automatic test_random_phases();
      int                  idle_mix  [4];
      int                  stall_mix [4];
      logic [PERIOD_W-1:0] mp;
      idle_mix  = '{0, 66, 0, 19};
      stall_mix = '{0, 0, 66, 19};
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       mp = PERIOD_W'($urandom_range(6, 1));
            1:       mp = 16'd0;
            2:       mp = 16'd2;
            default: mp = PERIOD_W'($urandom_range(16'hFFFF));
         endcase
         write_min_period(mp);
         idle_pct  = idle_mix[ph];
         stall_pct = stall_mix[ph];
         repeat (ITEMS_PER_PHASE) send_random_word();
      end
      wait_idle();
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   initial begin
      clear_table();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_min_period();
      test_backpressure();
      test_random_phases();
      wait_idle();
      repeat (END_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("timer_deadline_scheduler_top_tb passed");
      else
         $display("timer_deadline_scheduler_top_tb failed");
      $finish;
   end

endmodule
